// File: rtl/core/earliest_free_server_scheduler_macros.svh
// assertion macros shared by the scheduler modules
// no dependencies; taken in by `include where assertions are written
`ifndef EARLIEST_FREE_SERVER_SCHEDULER_MACROS_SVH
`define EARLIEST_FREE_SERVER_SCHEDULER_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define EFSS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("efss assertion failed");

// next-cycle implication, disabled while reset is held
`define EFSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("efss assertion failed");

`endif

// File: rtl/core/efss_pkg.sv
// shared types and fixed widths of the earliest-free-server scheduler
// no dependencies; used by the cfg and result interfaces, efss_ctrl, efss_dp and the top level
package efss_pkg;

    // fixed field widths
    localparam int CFG_W     = 5;
    localparam int SRV_OUT_W = 4;
    localparam int CLOCK_W   = 32;
    localparam int WAIT_W    = 48;

    // server count after reset
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd1;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic scan;
        logic update;
        logic load_out;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic greedy;
        logic cnt_end;
    } t_dp_status;

endpackage

// File: rtl/core/efss_cfg_if.sv
// configuration write channel: server count
// depends on efss_pkg
interface efss_cfg_if ();
    logic                        valid;
    logic                        ready;
    logic [efss_pkg::CFG_W-1:0]  servers_in_use;

    modport source (output valid, servers_in_use, input ready);
    modport sink   (input valid, servers_in_use, output ready);
endinterface

// File: rtl/core/efss_job_if.sv
// job input channel: service time and last-job flag
// no package dependency
interface efss_job_if #(
    parameter int SERVICE_BITS = 16
) ();
    logic                    valid;
    logic                    ready;
    logic [SERVICE_BITS-1:0] service_time;
    logic                    last_job;

    modport source (output valid, service_time, last_job, input ready);
    modport sink   (input valid, service_time, last_job, output ready);
endinterface

// File: rtl/core/efss_res_if.sv
// result channel: server, start time and batch totals
// depends on efss_pkg
interface efss_res_if ();
    logic                             valid;
    logic                             ready;
    logic [efss_pkg::SRV_OUT_W-1:0]   assigned_server;
    logic [efss_pkg::CLOCK_W-1:0]     start_time;
    logic                             batch_done;
    logic [efss_pkg::CLOCK_W-1:0]     finish_time;
    logic [efss_pkg::WAIT_W-1:0]      total_wait;

    modport source (output valid, assigned_server, start_time, batch_done, finish_time,
                    total_wait, input ready);
    modport sink   (input valid, assigned_server, start_time, batch_done, finish_time,
                    total_wait, output ready);
endinterface

// File: rtl/core/efss_ram.sv
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module efss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/efss_ctrl.sv
// controller: sequences scan, update and result load for one job
// depends on efss_pkg and the macros header
`include "earliest_free_server_scheduler_macros.svh"

module efss_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  efss_pkg::t_dp_status i_status,
    output efss_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_UPDATE = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_status.greedy ? S_SCAN : S_UPDATE;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.cnt_end) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                if (i_status.cnt_end) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output valid: set on load, cleared when the beat is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // checks
    `EFSS_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, (i_in_valid && o_in_ready), (r_state != S_IDLE))
    `EFSS_ASSERT_IMPLY(a_load_when_free, i_clk, i_rst_n, o_cmd.load_out, (!r_out_valid || i_out_ready))
    `EFSS_ASSERT_NEXT(a_finish_waits, i_clk, i_rst_n, (r_state == S_FINISH && r_out_valid && !i_out_ready), (r_state == S_FINISH))

endmodule

// File: rtl/core/efss_dp.sv
// datapath: server timer ram, min scan, timer update, clock and totals
// depends on efss_pkg, efss_ram and the macros header
`include "earliest_free_server_scheduler_macros.svh"

module efss_dp #(
    parameter int MAX_SERVERS  = 16,
    parameter int SERVICE_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  efss_pkg::t_dp_cmd                 i_cmd,
    output efss_pkg::t_dp_status              o_status,
    input  logic [efss_pkg::CFG_W-1:0]        i_servers_in_use,
    input  logic [SERVICE_BITS-1:0]           i_service_time,
    input  logic                              i_last_job,
    output logic [efss_pkg::SRV_OUT_W-1:0]    o_assigned_server,
    output logic [efss_pkg::CLOCK_W-1:0]      o_start_time,
    output logic                              o_batch_done,
    output logic [efss_pkg::CLOCK_W-1:0]      o_finish_time,
    output logic [efss_pkg::WAIT_W-1:0]       o_total_wait
);

    localparam int IDX_W  = $clog2(MAX_SERVERS);
    localparam int CNT_W  = $clog2(MAX_SERVERS + 1);
    localparam int SUM_W  = efss_pkg::CLOCK_W + 1;
    localparam int WSUM_W = efss_pkg::WAIT_W + 1;

    // job and batch registers
    logic [SERVICE_BITS-1:0]      r_svc;
    logic                         r_last;
    logic [efss_pkg::CLOCK_W-1:0] r_clock;
    logic [efss_pkg::WAIT_W-1:0]  r_wait;
    logic [CNT_W-1:0]             r_js;
    logic [CNT_W-1:0]             r_cnt;
    logic [SERVICE_BITS-1:0]      r_best;
    logic [IDX_W-1:0]             r_chosen;
    logic [SERVICE_BITS-1:0]      r_max;

    // result registers
    logic [efss_pkg::SRV_OUT_W-1:0] r_out_server;
    logic [efss_pkg::CLOCK_W-1:0]   r_out_start;
    logic                           r_out_done;
    logic [efss_pkg::CLOCK_W-1:0]   r_out_finish;
    logic [efss_pkg::WAIT_W-1:0]    r_out_wait;

    logic [CNT_W-1:0]             w_p;
    logic                         w_greedy;
    logic                         w_cnt_end;
    logic                         w_have;
    logic [CNT_W-1:0]             w_prev;
    logic [IDX_W-1:0]             w_idx;
    logic                         w_rd_en;
    logic [SERVICE_BITS-1:0]      w_rd_data;
    logic                         w_take;
    logic [SERVICE_BITS-1:0]      w_best_nxt;
    logic [SUM_W-1:0]             w_clk_sum;
    logic [efss_pkg::CLOCK_W-1:0] w_clk_sat;
    logic [SERVICE_BITS-1:0]      w_upd_val;
    logic [SERVICE_BITS-1:0]      w_max_nxt;
    logic                         w_we;
    logic [SUM_W-1:0]             w_fin_sum;
    logic [efss_pkg::CLOCK_W-1:0] w_fin_sat;
    logic [WSUM_W-1:0]            w_wait_sum;
    logic [efss_pkg::WAIT_W-1:0]  w_wait_sat;

    // effective server count, clamped to one and to the table size
    always_comb begin
        if (i_servers_in_use == '0) begin
            w_p = CNT_W'(1);
        end else if (32'(i_servers_in_use) > 32'(MAX_SERVERS)) begin
            w_p = CNT_W'(MAX_SERVERS);
        end else begin
            w_p = CNT_W'(i_servers_in_use);
        end
    end

    assign w_greedy  = (r_js >= w_p);
    assign w_cnt_end = (r_cnt == w_p);
    assign w_have    = (r_cnt != '0);
    assign w_prev    = r_cnt - CNT_W'(1);
    assign w_idx     = w_prev[IDX_W-1:0];

    assign o_status.greedy  = w_greedy;
    assign o_status.cnt_end = w_cnt_end;

    // timer ram: read one server per cycle, write each back in the following cycle
    assign w_rd_en = (i_cmd.scan || i_cmd.update) && (r_cnt < w_p);
    assign w_we    = i_cmd.update && w_have;

    efss_ram #(
        .WIDTH (SERVICE_BITS),
        .DEPTH (MAX_SERVERS)
    ) u_timer_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_idx),
        .i_wdata (w_upd_val),
        .i_re    (w_rd_en),
        .i_raddr (r_cnt[IDX_W-1:0]),
        .o_rdata (w_rd_data)
    );

    // min search, first server seeds the running minimum
    assign w_take     = (w_idx == '0) || (w_rd_data < r_best);
    assign w_best_nxt = w_take ? w_rd_data : r_best;
    assign w_clk_sum  = {1'b0, r_clock} + SUM_W'(w_best_nxt);
    assign w_clk_sat  = w_clk_sum[efss_pkg::CLOCK_W] ? '1 : w_clk_sum[efss_pkg::CLOCK_W-1:0];

    // new timer value; servers not yet used in this batch count as idle
    always_comb begin
        if (w_idx == r_chosen) begin
            w_upd_val = r_svc;
        end else if (CNT_W'(w_idx) < r_js) begin
            w_upd_val = w_rd_data - r_best;
        end else begin
            w_upd_val = '0;
        end
    end

    assign w_max_nxt = ((w_idx == '0) || (w_upd_val > r_max)) ? w_upd_val : r_max;

    // finish time and running wait, both saturating
    assign w_fin_sum  = {1'b0, r_clock} + SUM_W'(r_max);
    assign w_fin_sat  = w_fin_sum[efss_pkg::CLOCK_W] ? '1 : w_fin_sum[efss_pkg::CLOCK_W-1:0];
    assign w_wait_sum = {1'b0, r_wait} + WSUM_W'(r_clock);
    assign w_wait_sat = w_wait_sum[efss_pkg::WAIT_W] ? '1 : w_wait_sum[efss_pkg::WAIT_W-1:0];

    // batch state: clock, wait sum, job count, pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock <= '0;
            r_wait  <= '0;
            r_js    <= '0;
            r_cnt   <= '0;
        end else if (i_cmd.accept) begin
            r_cnt <= '0;
            if (!w_greedy) begin
                r_js <= r_js + CNT_W'(1);
            end
        end else if (i_cmd.scan) begin
            if (w_cnt_end) begin
                r_clock <= w_clk_sat;
                r_cnt   <= '0;
            end else begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end else if (i_cmd.update) begin
            if (!w_cnt_end) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end else if (i_cmd.load_out) begin
            if (r_last) begin
                r_clock <= '0;
                r_wait  <= '0;
                r_js    <= '0;
            end else begin
                r_wait <= w_wait_sat;
            end
        end
    end

    // job payload, chosen server, running min and max
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_svc  <= i_service_time;
            r_last <= i_last_job;
            if (!w_greedy) begin
                r_chosen <= r_js[IDX_W-1:0];
                r_best   <= '0;
            end
        end else if (i_cmd.scan && w_have) begin
            r_best <= w_best_nxt;
            if (w_take) begin
                r_chosen <= w_idx;
            end
        end else if (i_cmd.update && w_have) begin
            r_max <= w_max_nxt;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_server <= efss_pkg::SRV_OUT_W'(r_chosen);
            r_out_start  <= r_clock;
            r_out_done   <= r_last;
            r_out_finish <= r_last ? w_fin_sat : '0;
            r_out_wait   <= r_last ? w_wait_sat : '0;
        end
    end

    assign o_assigned_server = r_out_server;
    assign o_start_time      = r_out_start;
    assign o_batch_done      = r_out_done;
    assign o_finish_time     = r_out_finish;
    assign o_total_wait      = r_out_wait;

    // checks
    `EFSS_ASSERT_IMPLY(a_cnt_in_range, i_clk, i_rst_n, (i_cmd.scan || i_cmd.update), (r_cnt <= w_p))
    `EFSS_ASSERT_NEXT(a_batch_clears, i_clk, i_rst_n, (i_cmd.load_out && r_last), (r_js == '0 && r_clock == '0 && r_wait == '0))
    `EFSS_ASSERT_NEXT(a_fill_counts, i_clk, i_rst_n, (i_cmd.accept && !w_greedy), (r_js == $past(r_js) + CNT_W'(1)))

endmodule

// File: rtl/core/earliest_free_server_scheduler.sv
// top level of the earliest-free-server scheduler: config register, controller, datapath
// depends on efss_pkg, the three channel interfaces, efss_ctrl and efss_dp
//
//   channel  dir  payload                                              beat when
//   i_cfg    in   servers_in_use                                       valid & ready
//   i_job    in   service_time, last_job                               valid & ready
//   o_res    out  assigned_server, start_time, batch_done,             valid & ready
//                 finish_time, total_wait
//
// a job while the batch is still filling servers goes straight to the rewrite pass; a later job
// first makes one pass over the timer ram to find the earliest free server, then a second pass
// rewrites every timer, one ram port pair serving one server per cycle.
// reset is synchronous and active low; it clears the batch, sets the server count to one.
// a result waiting on o_res stalls only the end of the next job, which is accepted meanwhile.
// i_cfg is always ready; the user must write it only while no job is in flight, the block does not enforce it.
module earliest_free_server_scheduler #(
    parameter int MAX_SERVERS  = 16,
    parameter int SERVICE_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    efss_cfg_if.sink          i_cfg,
    efss_job_if.sink          i_job,
    efss_res_if.source        o_res
);

    logic [efss_pkg::CFG_W-1:0] r_cfg;
    efss_pkg::t_dp_cmd          w_cmd;
    efss_pkg::t_dp_status       w_status;

    // server count register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= efss_pkg::CFG_RESET;
        end else if (i_cfg.valid) begin
            r_cfg <= i_cfg.servers_in_use;
        end
    end

    // sequencer
    efss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_job.valid),
        .o_in_ready  (i_job.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // timers, clock and totals
    efss_dp #(
        .MAX_SERVERS  (MAX_SERVERS),
        .SERVICE_BITS (SERVICE_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_servers_in_use  (r_cfg),
        .i_service_time    (i_job.service_time),
        .i_last_job        (i_job.last_job),
        .o_assigned_server (o_res.assigned_server),
        .o_start_time      (o_res.start_time),
        .o_batch_done      (o_res.batch_done),
        .o_finish_time     (o_res.finish_time),
        .o_total_wait      (o_res.total_wait)
    );

endmodule
